// ===== sv/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Types, constants and the brightness table shared by the touch press
// qualifier.
// ----------------------------------------------------------------------------
package tpq_pkg;

   localparam int ReadingW  = 22;
   localparam int TimeW     = 32;
   localparam int HoldW     = 16;
   localparam int ThrW      = 23;
   localparam int LevelOutW = 3;
   localparam int BrightW   = 8;

   localparam int CsrAddrW  = 4;
   localparam int CsrDataW  = 32;

   localparam int Levels    = 6;
   localparam int LevelW    = $clog2(Levels);
   localparam int TableSize = 6;

   // floor(x/5) = (x * ceil(2^25/5)) >> 25, exact for every 22-bit x
   localparam int Div5Shift = 25;
   localparam int Div5MulW  = 23;
   localparam logic [Div5MulW-1:0] Div5Mul = Div5MulW'(((1 << Div5Shift) + 4) / 5);
   localparam int ProdW     = ReadingW + Div5MulW;
   localparam int FifthW    = 20;
   localparam int TenthW    = FifthW - 1;

   localparam logic [FifthW-1:0] MinPressMargin   = FifthW'(100);
   localparam logic [TenthW-1:0] MinReleaseMargin = TenthW'(50);

   localparam logic [HoldW-1:0] PressHoldReset   = HoldW'(45);
   localparam logic [HoldW-1:0] ReleaseHoldReset = HoldW'(100);

   localparam logic [BrightW-1:0] BrightTable [TableSize] = '{
      8'd0, 8'd24, 8'd64, 8'd128, 8'd192, 8'd255
   };
   localparam logic [BrightW-1:0] BrightMax = 8'd255;

   typedef enum logic [1:0] {
      CsrInitBaseline = 2'd0,
      CsrPressHold    = 2'd1,
      CsrReleaseHold  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [ReadingW-1:0] reading;
      logic [TimeW-1:0]    now_ms;
   } req_type;

   typedef struct packed {
      logic                 touched;
      logic                 pressed_event;
      logic [LevelOutW-1:0] level;
      logic [BrightW-1:0]   brightness;
      logic [ReadingW-1:0]  tracked_baseline;
      logic [ThrW-1:0]      press_level;
   } rsp_type;

   function automatic logic [BrightW-1:0] brightness_of(input logic [LevelW-1:0] lvl);
      logic [BrightW-1:0] val;
      if (int'(lvl) < TableSize) begin
         val = BrightTable[3'(lvl)];
      end else begin
         val = BrightMax;
      end
      return val;
   endfunction

   function automatic logic [LevelW-1:0] level_step(input logic [LevelW-1:0] lvl);
      logic [LevelW-1:0] nxt;
      if (lvl == LevelW'(Levels - 1)) begin
         nxt = '0;
      end else begin
         nxt = lvl + LevelW'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== sv/touch_press_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// touch_press_qualifier_top
// Debounced press detection on a capacitive touch plate with baseline
// tracking and a wrapping brightness level.
//
// Usage:
//   req channel: one beat per sample, carrying the averaged reading and a
//   millisecond timestamp. rsp channel: exactly one beat per req beat, in
//   order, with the qualified touch state, press event, level, brightness,
//   tracked baseline and the press threshold of that sample.
//   rsp valid rises once the beat has passed the input register and the
//   result register. Throughput is one beat per cycle while rsp_stall is
//   low: a beat sits in the input register while the threshold, debounce
//   and drift logic evaluate it, and moves into the result register
//   together with the state update. The critical path is the 22x23
//   reciprocal multiply for baseline/5 feeding the threshold compare.
//   When rsp_stall is high the result register holds, the input register
//   still takes one more beat, and req_stall rises only when both are full.
//   Reset clears both stages, the touch state and level, and sets the hold
//   times to 45 ms (press) and 100 ms (release). The baseline is loaded from
//   the initial baseline register on the first sample after reset.
//   Registers at byte addresses 0, 4, 8: initial baseline, press hold,
//   release hold. Write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module touch_press_qualifier_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tpq_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tpq_pkg::rsp_type          rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [tpq_pkg::CsrAddrW-1:0] paddr,
   input  logic [tpq_pkg::CsrDataW-1:0] pwdata,
   output logic [tpq_pkg::CsrDataW-1:0] prdata,
   output logic                      pready
);
   import tpq_pkg::*;

   logic [ReadingW-1:0] init_baseline_ff;
   logic [HoldW-1:0]    press_hold_ff;
   logic [HoldW-1:0]    release_hold_ff;
   csr_idx_type         csr_idx;
   logic                csr_wr;

   logic                in_vld_ff;
   req_type             in_ff;
   logic                rsp_vld_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic                started_ff;
   logic [ReadingW-1:0] baseline_ff;
   logic [ReadingW-1:0] baseline_in;
   logic                latched_ff;
   logic                latched_in;
   logic                pending_ff;
   logic                pending_in;
   logic [TimeW-1:0]    since_ff;
   logic [TimeW-1:0]    since_in;
   logic [LevelW-1:0]   level_ff;
   logic [LevelW-1:0]   level_in;

   logic                advance;
   logic                take;
   logic                fire;

   logic [ReadingW-1:0] base;
   logic [ProdW-1:0]    prod;
   logic [FifthW-1:0]   fifth;
   logic [TenthW-1:0]   tenth;
   logic [FifthW-1:0]   press_margin;
   logic [TenthW-1:0]   release_margin;
   logic [ThrW-1:0]     press_thr;
   logic [ThrW-1:0]     release_thr;
   logic                candidate;
   logic [TimeW-1:0]    since_eff;
   logic [TimeW-1:0]    elapsed;
   logic [TimeW-1:0]    hold;
   logic                hold_met;
   logic                press_evt;
   logic [ReadingW+8:0] drift;

   // configuration port
   assign pready  = 1'b1;
   assign csr_idx = csr_idx_type'(paddr[3:2]);
   assign csr_wr  = psel & penable & pwrite & pready;

   always_comb begin
      unique case (csr_idx)
         CsrInitBaseline: prdata = CsrDataW'(init_baseline_ff);
         CsrPressHold:    prdata = CsrDataW'(press_hold_ff);
         CsrReleaseHold:  prdata = CsrDataW'(release_hold_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_baseline_ff <= '0;
         press_hold_ff    <= PressHoldReset;
         release_hold_ff  <= ReleaseHoldReset;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CsrInitBaseline: init_baseline_ff <= pwdata[ReadingW-1:0];
            CsrPressHold:    press_hold_ff    <= pwdata[HoldW-1:0];
            CsrReleaseHold:  release_hold_ff  <= pwdata[HoldW-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign advance   = ~rsp_vld_ff | ~rsp_stall;
   assign req_stall = in_vld_ff & ~advance;
   assign take      = req_valid & ~req_stall;
   assign fire      = in_vld_ff & advance;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // thresholds
   assign base  = started_ff ? baseline_ff : init_baseline_ff;
   assign prod  = ProdW'(base) * ProdW'(Div5Mul);
   assign fifth = prod[Div5Shift +: FifthW];
   assign tenth = fifth[FifthW-1:1];

   assign press_margin   = (fifth > MinPressMargin)   ? fifth : MinPressMargin;
   assign release_margin = (tenth > MinReleaseMargin) ? tenth : MinReleaseMargin;
   assign press_thr      = ThrW'(base) + ThrW'(press_margin);
   assign release_thr    = ThrW'(base) + ThrW'(release_margin);

   assign candidate = latched_ff ? (ThrW'(in_ff.reading) > release_thr)
                                 : (ThrW'(in_ff.reading) > press_thr);

   // debounce
   assign since_eff = pending_ff ? since_ff : in_ff.now_ms;
   assign elapsed   = in_ff.now_ms - since_eff;
   assign hold      = candidate ? TimeW'(press_hold_ff) : TimeW'(release_hold_ff);
   assign hold_met  = elapsed >= hold;

   always_comb begin
      latched_in = latched_ff;
      pending_in = 1'b0;
      since_in   = '0;
      press_evt  = 1'b0;
      level_in   = level_ff;
      if (candidate != latched_ff) begin
         if (hold_met) begin
            latched_in = candidate;
            if (candidate) begin
               press_evt = 1'b1;
               level_in  = level_step(level_ff);
            end
         end else begin
            pending_in = 1'b1;
            since_in   = since_eff;
         end
      end
   end

   // drift: (base*255 + reading) / 256
   assign drift = ({1'b0, base, 8'b0} - (ReadingW+9)'(base)) + (ReadingW+9)'(in_ff.reading);
   assign baseline_in = latched_in ? base : drift[8 +: ReadingW];

   always_comb begin
      rsp_in.touched          = latched_in;
      rsp_in.pressed_event    = press_evt;
      rsp_in.level            = LevelOutW'(level_in);
      rsp_in.brightness       = brightness_of(level_in);
      rsp_in.tracked_baseline = baseline_in;
      rsp_in.press_level      = press_thr;
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         started_ff <= 1'b0;
         baseline_ff <= '0;
         latched_ff <= 1'b0;
         pending_ff <= 1'b0;
         since_ff   <= '0;
         level_ff   <= '0;
      end else begin
         if (take) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            rsp_vld_ff <= in_vld_ff;
         end
         if (fire) begin
            started_ff  <= 1'b1;
            baseline_ff <= baseline_in;
            latched_ff  <= latched_in;
            pending_ff  <= pending_in;
            since_ff    <= since_in;
            level_ff    <= level_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_started_after_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> started_ff)
      else $error("state not marked started after a processed beat");

   a_pending_needs_start: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> started_ff)
      else $error("pending debounce before any sample");

   a_since_cleared: assert property (@(posedge clock) disable iff (reset)
      !pending_ff |-> (since_ff == '0))
      else $error("pending timestamp left over without pending flag");

   a_press_is_touched: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.pressed_event |-> rsp_ff.touched)
      else $error("press event without touched state");

   a_level_moves_on_press: assert property (@(posedge clock) disable iff (reset)
      fire && !press_evt |=> $stable(level_ff))
      else $error("level changed without a press");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && rsp_vld_ff)
      else $error("input stalled with a free stage");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch press qualifier. A directed script walks
// the thresholds, the press and release hold times, timestamp wrap and level
// wrap. Random touch bursts follow under several hold settings and idle
// patterns. Every result beat is checked against a cycle-free model of the
// qualifier run on each accepted sample, or against a fixed row's result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tpq_pkg::*;

   localparam logic [ReadingW-1:0] ReadingTop = 22'h3FFFFF;
   localparam logic [BrightW-1:0]  BrightSteps [6] = '{
      8'd0, 8'd24, 8'd64, 8'd128, 8'd192, 8'd255
   };
   localparam int ScriptRows   = 24;
   localparam int ZeroHoldRow  = 15;
   localparam int Segments     = 6;
   localparam int SegmentItems = 215;
   localparam int LongHoldOff  = 300;

   typedef struct packed {
      req_type sample;
      logic    fixed;
      rsp_type result;
   } script_row_type;

   script_row_type script [ScriptRows] = '{
      '{'{22'd0, 32'd0}, 1'b1, '{1'b0, 1'b0, 3'd0, 8'd0, 22'd1992, 23'd2400}},
      '{'{ReadingTop, 32'd100}, 1'b1, '{1'b0, 1'b0, 3'd0, 8'd0, 22'd18368, 23'd2390}},
      '{'{ReadingTop, 32'd144}, 1'b0, '0},
      '{'{ReadingTop, 32'd145}, 1'b0, '0},
      '{'{22'd0, 32'd200}, 1'b0, '0},
      '{'{22'd0, 32'd250}, 1'b0, '0},
      '{'{ReadingTop, 32'd260}, 1'b0, '0},
      '{'{22'd0, 32'd270}, 1'b0, '0},
      '{'{22'd0, 32'd369}, 1'b0, '0},
      '{'{22'd0, 32'd370}, 1'b0, '0},
      '{'{ReadingTop, 32'hFFFFFFE0}, 1'b0, '0},
      '{'{ReadingTop, 32'h00000000}, 1'b0, '0},
      '{'{ReadingTop, 32'h0000000D}, 1'b0, '0},
      '{'{22'd0, 32'd20}, 1'b0, '0},
      '{'{22'd0, 32'd120}, 1'b0, '0},
      '{'{ReadingTop, 32'd200}, 1'b0, '0},
      '{'{22'd0, 32'd201}, 1'b0, '0},
      '{'{ReadingTop, 32'd202}, 1'b0, '0},
      '{'{22'd0, 32'd202}, 1'b0, '0},
      '{'{ReadingTop, 32'd203}, 1'b0, '0},
      '{'{22'd0, 32'd204}, 1'b0, '0},
      '{'{ReadingTop, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{22'd0, 32'd0}, 1'b0, '0},
      '{'{ReadingTop, 32'd5}, 1'b0, '0}
   };

   int unsigned seg_press   [Segments] = '{20, 0, 65535, 65535, 0, 45};
   int unsigned seg_release [Segments] = '{40, 65535, 0, 65535, 0, 100};
   int unsigned seg_step    [Segments] = '{15, 30000, 30000, 40000, 60, 30};

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_payload;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_payload;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [CsrDataW-1:0] pwdata;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   // qualifier model state and register image
   logic                tq_started  = 1'b0;
   logic [ReadingW-1:0] tq_baseline = '0;
   logic                tq_latched  = 1'b0;
   logic                tq_pending  = 1'b0;
   logic [TimeW-1:0]    tq_since    = '0;
   int unsigned         tq_level    = 0;
   logic [ReadingW-1:0] cfg_init_base    = '0;
   logic [HoldW-1:0]    cfg_press_hold   = PressHoldReset;
   logic [HoldW-1:0]    cfg_release_hold = ReleaseHoldReset;

   rsp_type     qualified_q [$];
   int unsigned mismatches    = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        hold_off_ask  = 1'b0;
   logic        hold_off_done = 1'b0;
   int unsigned hold_off_left = 0;
   logic        finger_down   = 1'b0;

   always #1 clock = ~clock;

   touch_press_qualifier_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   function automatic logic [ThrW-1:0] press_threshold(input logic [ReadingW-1:0] b);
      logic [ReadingW-1:0] fifth;
      fifth = b / 5;
      return {1'b0, b} + ThrW'((fifth > 22'd100) ? fifth : 22'd100);
   endfunction

   function automatic logic [ThrW-1:0] release_threshold(input logic [ReadingW-1:0] b);
      logic [ReadingW-1:0] tenth;
      tenth = b / 10;
      return {1'b0, b} + ThrW'((tenth > 22'd50) ? tenth : 22'd50);
   endfunction

   function automatic rsp_type qualify_sample(input req_type s);
      rsp_type          r;
      logic [ThrW-1:0]  p_thr;
      logic [ThrW-1:0]  r_thr;
      logic             cand;
      logic             pressed;
      logic [TimeW-1:0] held;
      logic [HoldW-1:0] need;
      if (!tq_started) begin
         tq_baseline = cfg_init_base;
         tq_started  = 1'b1;
      end
      p_thr   = press_threshold(tq_baseline);
      r_thr   = release_threshold(tq_baseline);
      cand    = tq_latched ? ({1'b0, s.reading} > r_thr) : ({1'b0, s.reading} > p_thr);
      pressed = 1'b0;
      if (cand != tq_latched) begin
         if (!tq_pending) begin
            tq_pending = 1'b1;
            tq_since   = s.now_ms;
         end
         need = cand ? cfg_press_hold : cfg_release_hold;
         held = s.now_ms - tq_since;
         if (held >= TimeW'(need)) begin
            tq_latched = cand;
            tq_pending = 1'b0;
            tq_since   = '0;
            if (cand) begin
               tq_level = (tq_level + 1) % Levels;
               pressed  = 1'b1;
            end
         end
      end else begin
         tq_pending = 1'b0;
         tq_since   = '0;
      end
      if (!tq_latched) begin
         tq_baseline = ReadingW'((32'(tq_baseline) * 255 + 32'(s.reading)) / 256);
      end
      r.touched          = tq_latched;
      r.pressed_event    = pressed;
      r.level            = LevelOutW'(tq_level);
      r.brightness       = (tq_level < 6) ? BrightSteps[tq_level] : 8'd255;
      r.tracked_baseline = tq_baseline;
      r.press_level      = p_thr;
      return r;
   endfunction

   // mostly finger up/down bursts around the live thresholds, some noise
   function automatic logic [ReadingW-1:0] pick_reading();
      int unsigned      roll;
      logic [ThrW-1:0]  p_thr;
      logic [ThrW-1:0]  r_thr;
      logic [ThrW:0]    v;
      roll  = $urandom_range(99);
      p_thr = press_threshold(tq_baseline);
      r_thr = release_threshold(tq_baseline);
      if ($urandom_range(7) == 0) begin
         finger_down = !finger_down;
      end
      if (roll < 8) begin
         v = (ThrW + 1)'($urandom_range(0, 32'h3FFFFF));
      end else if (roll < 16) begin
         v = (ThrW + 1)'(r_thr + 1 + $urandom_range(0, p_thr - r_thr - 1));
      end else if (finger_down) begin
         v = (ThrW + 1)'(p_thr + 1 + $urandom_range(0, 3000));
      end else begin
         v = (ThrW + 1)'(r_thr - $urandom_range(0, (r_thr < 400) ? r_thr : 400));
      end
      if (v > ReadingTop) begin
         v = ReadingTop;
      end
      return ReadingW'(v);
   endfunction

   task automatic program_register(input csr_idx_type idx, input logic [CsrDataW-1:0] value);
      logic [CsrDataW-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrW'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CsrInitBaseline: begin
            cfg_init_base = value[ReadingW-1:0];
            want          = CsrDataW'(cfg_init_base);
         end
         CsrPressHold: begin
            cfg_press_hold = value[HoldW-1:0];
            want           = CsrDataW'(cfg_press_hold);
         end
         default: begin
            cfg_release_hold = value[HoldW-1:0];
            want             = CsrDataW'(cfg_release_hold);
         end
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("register %0d readback: want %0d, got %0d", idx, want, prdata);
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input req_type s, input logic fixed, input rsp_type fixed_rsp);
      rsp_type forecast;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (req_stall);
      forecast = qualify_sample(s);
      qualified_q.push_back(fixed ? fixed_rsp : forecast);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (qualified_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (qualified_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result beat with nothing outstanding");
            end
         end else begin
            want = qualified_q.pop_front();
            if (rsp_payload.touched !== want.touched ||
                rsp_payload.pressed_event !== want.pressed_event ||
                rsp_payload.level !== want.level ||
                rsp_payload.brightness !== want.brightness ||
                rsp_payload.tracked_baseline !== want.tracked_baseline ||
                rsp_payload.press_level !== want.press_level) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: want t%0d e%0d lv%0d br%0d bl%0d pl%0d",
                     want.touched, want.pressed_event, want.level,
                     want.brightness, want.tracked_baseline, want.press_level);
                  $display("          got  t%0d e%0d lv%0d br%0d bl%0d pl%0d",
                     rsp_payload.touched, rsp_payload.pressed_event, rsp_payload.level,
                     rsp_payload.brightness, rsp_payload.tracked_baseline,
                     rsp_payload.press_level);
               end
            end
         end
      end
      if (hold_off_ask && !hold_off_done) begin
         hold_off_done <= 1'b1;
         hold_off_left <= LongHoldOff;
         rsp_stall     <= 1'b1;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      int               i;
      int               seg;
      int               k;
      logic [TimeW-1:0] stamp_ms;
      req_type          s;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      program_register(CsrInitBaseline, 32'd2000);
      for (i = 0; i < ScriptRows; i++) begin
         if (i == ZeroHoldRow) begin
            drain_results();
            program_register(CsrPressHold, 32'd0);
            program_register(CsrReleaseHold, 32'd0);
            program_register(CsrInitBaseline, CsrDataW'(ReadingTop));
         end
         send_sample(script[i].sample, script[i].fixed, script[i].result);
      end
      drain_results();

      stamp_ms = 32'd1000;
      for (seg = 0; seg < Segments; seg++) begin
         send_idle_pct = (seg / 2 == 0) ? 24 : (seg / 2 == 1) ? 61 : 0;
         recv_idle_pct = (seg / 2 == 0) ? 61 : (seg / 2 == 1) ? 24 : 0;
         if (seg == 4) begin
            program_register(CsrPressHold, $urandom_range(0, 200));
            program_register(CsrReleaseHold, $urandom_range(0, 200));
         end else begin
            program_register(CsrPressHold, seg_press[seg]);
            program_register(CsrReleaseHold, seg_release[seg]);
         end
         program_register(CsrInitBaseline, $urandom_range(0, 32'h3FFFFF));
         if (seg == 4) begin
            hold_off_ask = 1'b1;
         end
         for (k = 0; k < SegmentItems; k++) begin
            if ($urandom_range(99) < 3) begin
               stamp_ms = $urandom;
            end else begin
               stamp_ms = stamp_ms + $urandom_range(0, seg_step[seg]);
            end
            s.reading = pick_reading();
            s.now_ms  = stamp_ms;
            send_sample(s, 1'b0, '0);
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && qualified_q.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
